// ===== hw/rtl/hop_framer_ring_top_assert.svh =====
// Assertion macros for the hop framer ring checker.
// Included by files that assert; expects clk_i and rst_ni in scope.
`ifndef HOP_FRAMER_RING_TOP_ASSERT_SVH
`define HOP_FRAMER_RING_TOP_ASSERT_SVH

// Condition and consequence in the same cycle.
`define HFR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequence in the cycle after the condition.
`define HFR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/hfr_pkg.sv =====
// Shared constants and types for the hop framer ring.
// No dependencies; imported by every module of the block except hfr_ram.
package hfr_pkg;

  localparam int FRAME_MAX   = 1024;
  localparam int SAMPLE_BITS = 24;
  localparam int RING_DEPTH  = 2 * FRAME_MAX;
  localparam int FIDX_W      = $clog2(FRAME_MAX);
  localparam int RIDX_W      = $clog2(RING_DEPTH);
  localparam int LEN_W       = $clog2(FRAME_MAX) + 1;
  localparam int FILL_W      = $clog2(RING_DEPTH) + 1;
  localparam int IN_TDATA_W  = ((SAMPLE_BITS + FIDX_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((1 + SAMPLE_BITS + FILL_W + 7) / 8) * 8;
  localparam int QUEUE_DEPTH = 2;

  localparam logic CFG_IDX_FRAME = 1'b0;
  localparam logic CFG_IDX_HOP   = 1'b1;

  typedef struct packed {
    logic                          is_read;
    logic                          block_end;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic [FIDX_W-1:0]             index;
  } hfr_cmd_t;

endpackage

// ===== hw/rtl/hfr_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module hfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== hw/rtl/hfr_front.sv =====
// Input side of the hop framer ring: accepts items, decodes them into commands
// and holds them in a short queue. Depends on hfr_pkg.
module hfr_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [hfr_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  input  logic [1:0]                         s_axis_tuser_i,
  input  logic                               s_axis_tlast_i,
  output logic                               cmd_valid_o,
  input  logic                               cmd_ready_i,
  output hfr_pkg::hfr_cmd_t                  cmd_o
);
  import hfr_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  hfr_cmd_t           queue_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [PTR_W:0]     count_q, count_d;
  hfr_cmd_t           cmd_in;
  logic               push, pop;

  always_comb begin
    cmd_in.is_read   = s_axis_tuser_i[0];
    cmd_in.block_end = s_axis_tlast_i & ~s_axis_tuser_i[0];
    cmd_in.sample    = s_axis_tuser_i[1] ? '0 : s_axis_tdata_i[SAMPLE_BITS-1:0];
    cmd_in.index     = s_axis_tdata_i[SAMPLE_BITS +: FIDX_W];
  end

  assign s_axis_tready_o = (count_q != (PTR_W+1)'(QUEUE_DEPTH));
  assign push            = s_axis_tvalid_i & s_axis_tready_o;
  assign cmd_valid_o     = (count_q != '0);
  assign pop             = cmd_valid_o & cmd_ready_i;
  assign cmd_o           = queue_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

// ===== hw/rtl/hfr_back.sv =====
// Execution side of the hop framer ring: ring and frame memories, pointers,
// frame copy sequencer, configuration and the output register.
// Depends on hfr_pkg and hfr_ram.
module hfr_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic                               cfg_idx_i,
  input  logic [hfr_pkg::LEN_W-1:0]          cfg_data_i,
  input  logic                               cmd_valid_i,
  output logic                               cmd_ready_o,
  input  hfr_pkg::hfr_cmd_t                  cmd_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  output logic [hfr_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o
);
  import hfr_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_RDWAIT = 2'd1;
  localparam logic [1:0] ST_COPY   = 2'd2;

  logic [1:0]              state_q, state_d;
  logic [LEN_W-1:0]        frame_q, hop_q;
  logic [RIDX_W-1:0]       wr_pos_q, wr_pos_d;
  logic [RIDX_W-1:0]       rd_pos_q, rd_pos_d;
  logic [FILL_W-1:0]       fill_q, fill_d;
  logic                    ready_q, ready_d;
  logic [LEN_W-1:0]        hwm_q, hwm_d;
  logic [LEN_W-1:0]        cnt_q, cnt_d;
  logic [RIDX_W-1:0]       raddr_q, raddr_d;
  logic                    pend_q, pend_d;
  logic [FIDX_W-1:0]       widx_q, widx_d;
  logic                    rvalid_q, rvalid_d;

  logic                    out_valid_q, out_valid_d;
  logic                    out_ready_q, out_ready_d;
  logic [SAMPLE_BITS-1:0]  out_data_q, out_data_d;
  logic [FILL_W-1:0]       out_fill_q, out_fill_d;

  logic [FILL_W-1:0]       cap;
  logic [LEN_W-1:0]        hop_eff;
  logic [LEN_W-1:0]        frame_eff_in;
  logic [FILL_W-1:0]       fill_inc;
  logic [FILL_W-1:0]       rd_sum;
  logic                    out_free, pop, issue, done;
  logic [SAMPLE_BITS-1:0]  ring_rdata, frame_rdata;

  assign cap     = {frame_q, 1'b0};
  assign hop_eff = (hop_q == '0 || hop_q > frame_q) ? frame_q : hop_q;
  assign fill_inc = (fill_q < cap) ? fill_q + 1'b1 : fill_q;
  assign rd_sum   = {1'b0, rd_pos_q} + {1'b0, hop_eff};

  always_comb begin
    frame_eff_in = cfg_data_i;
    if (cfg_data_i == '0) begin
      frame_eff_in = LEN_W'(1);
    end else if (cfg_data_i > LEN_W'(FRAME_MAX)) begin
      frame_eff_in = LEN_W'(FRAME_MAX);
    end
  end

  assign out_free    = ~out_valid_q | m_axis_tready_i;
  assign cmd_ready_o = (state_q == ST_IDLE) & out_free;
  assign pop         = cmd_valid_i & cmd_ready_o;
  assign issue       = (state_q == ST_COPY) & (cnt_q < frame_q);
  assign done        = (state_q == ST_COPY) & ~(cnt_q < frame_q) & pend_q;

  always_comb begin
    state_d     = state_q;
    wr_pos_d    = wr_pos_q;
    rd_pos_d    = rd_pos_q;
    fill_d      = fill_q;
    ready_d     = ready_q;
    hwm_d       = hwm_q;
    cnt_d       = cnt_q;
    raddr_d     = raddr_q;
    pend_d      = 1'b0;
    widx_d      = widx_q;
    rvalid_d    = rvalid_q;
    out_valid_d = out_valid_q & ~m_axis_tready_i;
    out_ready_d = out_ready_q;
    out_data_d  = out_data_q;
    out_fill_d  = out_fill_q;

    case (state_q)
      ST_IDLE: begin
        if (pop) begin
          if (cmd_i.is_read) begin
            rvalid_d = ({1'b0, cmd_i.index} < frame_q) && ({1'b0, cmd_i.index} < hwm_q);
            state_d  = ST_RDWAIT;
          end else begin
            wr_pos_d = ({1'b0, wr_pos_q} + 1'b1 == cap) ? '0 : wr_pos_q + 1'b1;
            fill_d   = fill_inc;
            if (cmd_i.block_end && fill_inc >= {1'b0, frame_q}) begin
              cnt_d   = '0;
              raddr_d = rd_pos_q;
              state_d = ST_COPY;
            end else begin
              if (cmd_i.block_end) begin
                ready_d = 1'b0;
              end
              out_valid_d = 1'b1;
              out_ready_d = cmd_i.block_end ? 1'b0 : ready_q;
              out_data_d  = '0;
              out_fill_d  = fill_inc;
            end
          end
        end
      end
      ST_RDWAIT: begin
        out_valid_d = 1'b1;
        out_ready_d = ready_q;
        out_data_d  = rvalid_q ? frame_rdata : '0;
        out_fill_d  = fill_q;
        state_d     = ST_IDLE;
      end
      ST_COPY: begin
        if (issue) begin
          cnt_d   = cnt_q + 1'b1;
          raddr_d = ({1'b0, raddr_q} + 1'b1 == cap) ? '0 : raddr_q + 1'b1;
          pend_d  = 1'b1;
          widx_d  = cnt_q[FIDX_W-1:0];
        end
        if (done) begin
          rd_pos_d    = (rd_sum >= cap) ? RIDX_W'(rd_sum - cap) : rd_sum[RIDX_W-1:0];
          fill_d      = fill_q - {1'b0, hop_eff};
          ready_d     = 1'b1;
          hwm_d       = (frame_q > hwm_q) ? frame_q : hwm_q;
          out_valid_d = 1'b1;
          out_ready_d = 1'b1;
          out_data_d  = '0;
          out_fill_d  = fill_q - {1'b0, hop_eff};
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cfg_we_i) begin
      wr_pos_d = '0;
      rd_pos_d = '0;
      fill_d   = '0;
      ready_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      frame_q     <= LEN_W'(FRAME_MAX);
      hop_q       <= '0;
      wr_pos_q    <= '0;
      rd_pos_q    <= '0;
      fill_q      <= '0;
      ready_q     <= 1'b0;
      hwm_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wr_pos_q    <= wr_pos_d;
      rd_pos_q    <= rd_pos_d;
      fill_q      <= fill_d;
      ready_q     <= ready_d;
      hwm_q       <= hwm_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_IDX_FRAME) begin
          frame_q <= frame_eff_in;
        end else begin
          hop_q <= cfg_data_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q       <= cnt_d;
    raddr_q     <= raddr_d;
    widx_q      <= widx_d;
    rvalid_q    <= rvalid_d;
    out_ready_q <= out_ready_d;
    out_data_q  <= out_data_d;
    out_fill_q  <= out_fill_d;
  end

  hfr_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(RING_DEPTH)
  ) u_ring_ram (
    .clk_i  (clk_i),
    .we_i   (pop & ~cmd_i.is_read),
    .waddr_i(wr_pos_q),
    .wdata_i(cmd_i.sample),
    .re_i   (issue),
    .raddr_i(raddr_q),
    .rdata_o(ring_rdata)
  );

  hfr_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(FRAME_MAX)
  ) u_frame_ram (
    .clk_i  (clk_i),
    .we_i   ((state_q == ST_COPY) & pend_q),
    .waddr_i(widx_q),
    .wdata_i(ring_rdata),
    .re_i   (pop & cmd_i.is_read),
    .raddr_i(cmd_i.index),
    .rdata_o(frame_rdata)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(OUT_TDATA_W - FILL_W - SAMPLE_BITS - 1)'(0),
                            out_fill_q, out_data_q, out_ready_q};

endmodule

// ===== hw/rtl/hop_framer_ring_top.sv =====
// Top level of the hop framer ring: input queue front end and execution back end.
// Depends on hfr_pkg, hfr_front, hfr_back and hfr_ram.
//
// Sliding-window framer. Each item is either a sample push or a read of one word
// of the last emitted frame; each item yields exactly one result carrying the
// frame-ready flag, the read word (zero for pushes) and the ring fill level. A
// push that ends a block with enough samples buffered copies the frame out of
// the ring one sample per cycle through the ring's single read port. Items keep
// arriving into a two-entry queue while the back end is busy. There is no
// clearing pass after reset: frame words that were never copied read as zero.
// Configuration writes restart the framer and are only legal while the block
// is idle.
module hop_framer_ring_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic                               cfg_idx_i,
  input  logic [hfr_pkg::LEN_W-1:0]          cfg_data_i,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // Fields from bit 0: sample[23:0], read_index[33:24], zero padding.
  input  logic [hfr_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  // Fields from bit 0: func[0], muted[1].
  input  logic [1:0]                         s_axis_tuser_i,
  // Carries block_end.
  input  logic                               s_axis_tlast_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // Fields from bit 0: frame_ready[0], read_data[24:1], fill_level[36:25], zero padding.
  output logic [hfr_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o
);
  import hfr_pkg::*;

  logic     cmd_valid;
  logic     cmd_ready;
  hfr_cmd_t cmd;

  hfr_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .cmd_valid_o    (cmd_valid),
    .cmd_ready_i    (cmd_ready),
    .cmd_o          (cmd)
  );

  hfr_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .cmd_valid_i    (cmd_valid),
    .cmd_ready_o    (cmd_ready),
    .cmd_i          (cmd),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

endmodule

// ===== hw/rtl/hfr_checker.sv =====
// Port-level checker for the hop framer ring, bound to the top level.
// Depends on hfr_pkg and hop_framer_ring_top_assert.svh.
`include "hop_framer_ring_top_assert.svh"

module hfr_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               m_axis_tvalid_o,
  input logic                               m_axis_tready_i,
  input logic [hfr_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o
);
  import hfr_pkg::*;

  logic                                      out_valid;
  logic                                      out_stall;
  logic [OUT_TDATA_W-1:0]                    out_data;
  logic [FILL_W-1:0]                         out_fill;
  logic [OUT_TDATA_W-SAMPLE_BITS-FILL_W-2:0] out_pad;

  assign out_valid = m_axis_tvalid_o;
  assign out_stall = m_axis_tvalid_o & ~m_axis_tready_i;
  assign out_data  = m_axis_tdata_o;
  assign out_fill  = m_axis_tdata_o[SAMPLE_BITS+1 +: FILL_W];
  assign out_pad   = m_axis_tdata_o[OUT_TDATA_W-1:SAMPLE_BITS+FILL_W+1];

  `HFR_ASSERT_NXT(a_out_hold, out_stall, out_valid && $stable(out_data), "stalled item changed")

  `HFR_ASSERT_IMP(a_fill_max, out_valid, out_fill <= FILL_W'(RING_DEPTH), "fill above capacity")

  `HFR_ASSERT_IMP(a_pad_zero, out_valid, out_pad == '0, "output padding not zero")

endmodule

bind hop_framer_ring_top hfr_checker u_hfr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o)
);
